### design/ypt_pkg.sv
// Shared types, constants and the RGB to Y6 V5 U5 conversion for the
// YUV655 palette/tint pixel pipe. No dependencies.
package ypt_pkg;

    // Palette store geometry
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam logic [8:0] SLOT_LIMIT = 9'(PALETTE_ENTRIES);

    // Queue depths
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
    localparam int OQ_DEPTH   = 4;
    localparam int OQ_AW      = $clog2(OQ_DEPTH);
    localparam int OQ_CW      = $clog2(OQ_DEPTH + 1);

    // Special palette slot
    localparam logic [7:0]  FORCED_SLOT  = 8'd255;
    localparam logic [15:0] FORCED_ENTRY = 16'h7FFF;

    // Blend rounding term (same for all channels once the field shifts fold away)
    localparam logic [14:0] BLEND_RND = 15'd8;

    // Request types on the input item
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_DIRECT_MODE = 3'd0;
    localparam logic [2:0] REG_TINT_RED    = 3'd1;
    localparam logic [2:0] REG_TINT_GREEN  = 3'd2;
    localparam logic [2:0] REG_TINT_BLUE   = 3'd3;
    localparam logic [2:0] REG_TINT_RATIO  = 3'd4;

    // Command kinds passed from front to back
    typedef logic [1:0] t_cmd_kind;
    localparam t_cmd_kind CMD_WRITE  = 2'd0;
    localparam t_cmd_kind CMD_LOOKUP = 2'd1;
    localparam t_cmd_kind CMD_DIRECT = 2'd2;

    typedef struct packed {
        t_cmd_kind          kind;
        logic               hit;    // lookup index inside the palette
        logic [PAL_AW-1:0]  addr;
        logic [15:0]        data;   // converted entry, or direct pixel
    } t_cmd;

    typedef struct packed {
        logic        direct_mode;
        logic [7:0]  ratio;
        logic [15:0] tint;          // tint color already in Y6 V5 U5
    } t_cfg;

    // Saturate a signed value to 0..255
    function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
        logic [7:0] res;
        if (v < 11'sd0) begin
            res = 8'd0;
        end else if (v > 11'sd255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    // RGB to packed Y6 V5 U5; rnd adds the +1 / +3 rounding offsets
    function automatic logic [15:0] rgb_to_yuv655(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b, input logic rnd);
        logic [9:0]         ysum;
        logic signed [9:0]  du;
        logic signed [9:0]  dv;
        logic signed [9:0]  hu;
        logic signed [9:0]  hv;
        logic signed [10:0] yv;
        logic signed [10:0] uv;
        logic signed [10:0] vv;
        logic [7:0]         ys;
        logic [7:0]         us;
        logic [7:0]         vs;
        ysum = {1'b0, g, 1'b0} + {2'b00, r} + {2'b00, b};
        du   = $signed({2'b00, b}) - $signed({2'b00, g});
        dv   = $signed({2'b00, r}) - $signed({2'b00, g});
        // halve, truncating toward zero
        hu   = $signed(du + 10'(du[9])) >>> 1;
        hv   = $signed(dv + 10'(dv[9])) >>> 1;
        yv   = $signed({3'b000, ysum[9:2]}) + (rnd ? 11'sd1 : 11'sd0);
        uv   = $signed({hu[9], hu}) + 11'sd128 + (rnd ? 11'sd3 : 11'sd0);
        vv   = $signed({hv[9], hv}) + 11'sd128 + (rnd ? 11'sd3 : 11'sd0);
        ys   = clamp_byte(yv);
        us   = clamp_byte(uv);
        vs   = clamp_byte(vv);
        return {ys[7:2], vs[7:3], us[7:3]};
    endfunction

endpackage

### design/ypt_front.sv
// Front stage: accepts input items, classifies them and converts palette colors.
// Depends on ypt_pkg; feeds ypt_cmd_q.
module ypt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic             i_req_type,
    input  logic [7:0]       i_slot_or_index,
    input  logic [7:0]       i_red_in,
    input  logic [7:0]       i_green_in,
    input  logic [7:0]       i_blue_in,
    input  logic [15:0]      i_pixel_word,
    input  logic             i_direct_mode,
    input  logic             i_q_full,
    output logic             o_q_push,
    output ypt_pkg::t_cmd    o_q_cmd
);
    import ypt_pkg::*;

    logic  r_valid;
    logic  r_keep;
    t_cmd  r_cmd;
    logic  n_keep;
    t_cmd  n_cmd;
    logic  advance;
    logic  accept;
    logic  in_range;

    assign advance = !r_valid || !i_q_full;
    assign accept  = i_push && advance;
    assign o_full  = !advance;

    // Classify the incoming item
    always_comb begin
        in_range    = {1'b0, i_slot_or_index} < SLOT_LIMIT;
        n_cmd.addr  = i_slot_or_index[PAL_AW-1:0];
        n_cmd.hit   = in_range;
        n_keep      = 1'b1;
        if (i_req_type == REQ_WRITE) begin
            n_cmd.kind = CMD_WRITE;
            n_keep     = in_range;   // writes beyond the store are dropped
            n_cmd.data = (i_slot_or_index == FORCED_SLOT) ? FORCED_ENTRY
                       : rgb_to_yuv655(i_red_in, i_green_in, i_blue_in, 1'b1);
        end else if (i_direct_mode) begin
            n_cmd.kind = CMD_DIRECT;
            n_cmd.data = i_pixel_word;
        end else begin
            n_cmd.kind = CMD_LOOKUP;
            n_cmd.data = i_pixel_word;
        end
    end

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= accept;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= n_cmd;
            r_keep <= n_keep;
        end
    end

    assign o_q_push = r_valid && r_keep && !i_q_full;
    assign o_q_cmd  = r_cmd;

endmodule

### design/ypt_cmd_q.sv
// Short command queue between the front and back stages.
// Depends on ypt_pkg.
module ypt_cmd_q (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ypt_pkg::t_cmd    i_cmd,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output ypt_pkg::t_cmd    o_cmd
);
    import ypt_pkg::*;

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wp;
    logic [CMDQ_AW-1:0] r_rp;
    logic [CMDQ_CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CMDQ_CW'(CMDQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : r_wp + CMDQ_AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : r_rp + CMDQ_AW'(1);
            end
            r_cnt <= r_cnt + CMDQ_CW'(i_push) - CMDQ_CW'(i_pop);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

### design/ypt_back.sv
// Back stage: palette store, tint blend multipliers and the result queue.
// Depends on ypt_pkg; takes commands from ypt_cmd_q.
module ypt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  ypt_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    input  ypt_pkg::t_cfg    i_cfg,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [15:0]      o_out_pixel
);
    import ypt_pkg::*;

    // Palette store, undefined until written
    logic [15:0]      r_pal [PALETTE_ENTRIES];
    logic [15:0]      r_pal_rd;

    // Execute stage
    logic             r_e_valid;
    logic             r_e_lookup;
    logic             r_e_hit;
    logic             r_e_pass;
    logic [15:0]      r_e_pix;
    logic [13:0]      r_py_a;
    logic [13:0]      r_py_b;
    logic [13:0]      r_pu_a;
    logic [13:0]      r_pu_b;
    logic [13:0]      r_pv_a;
    logic [13:0]      r_pv_b;

    // Result queue
    logic [15:0]      r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0] r_oq_wp;
    logic [OQ_AW-1:0] r_oq_rp;
    logic [OQ_CW-1:0] r_oq_cnt;

    logic [7:0]       inv;
    logic [OQ_CW:0]   reserved;
    logic             oq_pop;
    logic [14:0]      sum_y;
    logic [14:0]      sum_u;
    logic [14:0]      sum_v;
    logic [15:0]      blend;
    logic [15:0]      result;

    // Take a command only while the result queue has room for it
    assign reserved  = (OQ_CW + 1)'(r_oq_cnt) + (OQ_CW + 1)'(r_e_valid);
    assign o_cmd_pop = i_cmd_valid && (reserved < (OQ_CW + 1)'(OQ_DEPTH));
    assign inv       = 8'd255 - i_cfg.ratio;

    // Palette store port: one write or one registered read per command
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.kind == CMD_WRITE) begin
            r_pal[i_cmd.addr] <= i_cmd.data;
        end
        if (o_cmd_pop && i_cmd.kind == CMD_LOOKUP) begin
            r_pal_rd <= r_pal[i_cmd.addr];
        end
    end

    // Execute stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else begin
            r_e_valid <= o_cmd_pop && (i_cmd.kind != CMD_WRITE);
        end
    end

    // Blend products per channel, pixel weight and tint weight
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_e_lookup <= (i_cmd.kind == CMD_LOOKUP);
            r_e_hit    <= i_cmd.hit;
            r_e_pass   <= (i_cfg.ratio == 8'd0);
            r_e_pix    <= i_cmd.data;
            r_py_a     <= 14'(inv) * 14'(i_cmd.data[15:10]);
            r_py_b     <= 14'(i_cfg.ratio) * 14'(i_cfg.tint[15:10]);
            r_pu_a     <= 14'(inv) * 14'(i_cmd.data[4:0]);
            r_pu_b     <= 14'(i_cfg.ratio) * 14'(i_cfg.tint[4:0]);
            r_pv_a     <= 14'(inv) * 14'(i_cmd.data[9:5]);
            r_pv_b     <= 14'(i_cfg.ratio) * 14'(i_cfg.tint[9:5]);
        end
    end

    // Round and pick the field bits; each channel reduces to (a + b + 8) >> 8
    always_comb begin
        sum_y = 15'(r_py_a) + 15'(r_py_b) + BLEND_RND;
        sum_u = 15'(r_pu_a) + 15'(r_pu_b) + BLEND_RND;
        sum_v = 15'(r_pv_a) + 15'(r_pv_b) + BLEND_RND;
        blend = {sum_y[13:8], sum_v[12:8], sum_u[12:8]};
        if (r_e_lookup) begin
            result = r_e_hit ? r_pal_rd : 16'd0;
        end else if (r_e_pass) begin
            result = r_e_pix;
        end else begin
            result = blend;
        end
    end

    // Result queue control
    assign oq_pop      = i_pop && !o_empty;
    assign o_empty     = (r_oq_cnt == '0);
    assign o_out_pixel = r_oq[r_oq_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (r_e_valid) begin
                r_oq_wp <= (r_oq_wp == OQ_AW'(OQ_DEPTH - 1)) ? '0 : r_oq_wp + OQ_AW'(1);
            end
            if (oq_pop) begin
                r_oq_rp <= (r_oq_rp == OQ_AW'(OQ_DEPTH - 1)) ? '0 : r_oq_rp + OQ_AW'(1);
            end
            r_oq_cnt <= r_oq_cnt + OQ_CW'(r_e_valid) - OQ_CW'(oq_pop);
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (r_e_valid) begin
            r_oq[r_oq_wp] <= result;
        end
    end

endmodule

### design/yuv655_palette_tint_pixel_pipe.sv
// Top level of the YUV655 palette/tint pixel pipe: register port and wiring.
// Depends on ypt_pkg, ypt_front, ypt_cmd_q and ypt_back.
//
//  channel   direction  handshake              payload
//  input     in         push / full            i_req_type, i_slot_or_index, i_red_in,
//                                              i_green_in, i_blue_in, i_pixel_word
//  result    out        empty / pop            o_out_pixel (pixel items only)
//  config    in/out     psel/penable/pwrite    paddr, pwdata, prdata, pready
//
//  One item per clock sustained while nothing stalls; the palette store has one port and
//  serves one command per cycle in the back stage while the result queue has room. A pixel
//  result passes the front register, command queue, execute stage and result queue in turn.
//  Reset is synchronous; no clearing pass (palette entries are undefined until written).
//  A stalled result side fills the result queue, then the command queue, then full rises.
module yuv655_palette_tint_pixel_pipe (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input item queue
    input  logic         push,
    output logic         full,
    input  logic         i_req_type,
    input  logic [7:0]   i_slot_or_index,
    input  logic [7:0]   i_red_in,
    input  logic [7:0]   i_green_in,
    input  logic [7:0]   i_blue_in,
    input  logic [15:0]  i_pixel_word,
    // result queue
    output logic         empty,
    input  logic         pop,
    output logic [15:0]  o_out_pixel,
    // register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import ypt_pkg::*;

    logic        r_direct_mode;
    logic [7:0]  r_tint_red;
    logic [7:0]  r_tint_green;
    logic [7:0]  r_tint_blue;
    logic [7:0]  r_tint_ratio;
    logic [15:0] r_tint_yuv;

    logic        wr_en;
    logic [2:0]  reg_idx;
    t_cfg        cfg;
    logic        q_push;
    logic        q_full;
    t_cmd        q_in_cmd;
    logic        q_valid;
    logic        q_pop;
    t_cmd        q_out_cmd;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direct_mode <= 1'b1;
            r_tint_red    <= 8'd0;
            r_tint_green  <= 8'd0;
            r_tint_blue   <= 8'd0;
            r_tint_ratio  <= 8'd0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DIRECT_MODE: r_direct_mode <= pwdata[0];
                REG_TINT_RED:    r_tint_red    <= pwdata[7:0];
                REG_TINT_GREEN:  r_tint_green  <= pwdata[7:0];
                REG_TINT_BLUE:   r_tint_blue   <= pwdata[7:0];
                REG_TINT_RATIO:  r_tint_ratio  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (reg_idx)
            REG_DIRECT_MODE: prdata = {31'd0, r_direct_mode};
            REG_TINT_RED:    prdata = {24'd0, r_tint_red};
            REG_TINT_GREEN:  prdata = {24'd0, r_tint_green};
            REG_TINT_BLUE:   prdata = {24'd0, r_tint_blue};
            REG_TINT_RATIO:  prdata = {24'd0, r_tint_ratio};
            default:         prdata = 32'd0;
        endcase
    end

    // Tint color in pixel format, no rounding offsets
    always_ff @(posedge i_clk) begin
        r_tint_yuv <= rgb_to_yuv655(r_tint_red, r_tint_green, r_tint_blue, 1'b0);
    end

    assign cfg.direct_mode = r_direct_mode;
    assign cfg.ratio       = r_tint_ratio;
    assign cfg.tint        = r_tint_yuv;

    ypt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_req_type      (i_req_type),
        .i_slot_or_index (i_slot_or_index),
        .i_red_in        (i_red_in),
        .i_green_in      (i_green_in),
        .i_blue_in       (i_blue_in),
        .i_pixel_word    (i_pixel_word),
        .i_direct_mode   (cfg.direct_mode),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_cmd         (q_in_cmd)
    );

    ypt_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    ypt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_out_cmd),
        .o_cmd_pop   (q_pop),
        .i_cfg       (cfg),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_pixel (o_out_pixel)
    );

    // Back stage never takes from an empty command queue
    a_pop_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("command taken from empty queue");

    // Front never pushes into a full command queue
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    // Out of reset both queues read empty and input is open
    a_reset_clean: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (empty && !full && !q_valid))
        else $error("queues not empty after reset");

    // A command queued while the back side is free is taken the next cycle
    a_back_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && !q_valid && empty && !$past(q_pop) && $past(empty)) |=> q_pop)
        else $error("back stage stalled with room available");

endmodule
